FILE: design/trsmc_pkg.sv
// ----------------------------------------------------------------------------
// trsmc_pkg
// Shared constants, stage types and arithmetic helpers of the TRS matrix core.
// ----------------------------------------------------------------------------
package trsmc_pkg;

  localparam int DefCordicStages = 16;
  localparam int DefFracBits     = 16;

  localparam int TurnW    = 32;  // binary angle, full turn = 2^32
  localparam int XyW      = 34;  // CORDIC x/y, Q30 with headroom
  localparam int ZW       = 33;  // CORDIC residual angle
  localparam int Rq30W    = 34;  // rounded Q30 products and rotation entries
  localparam int ProdW    = 66;  // raw products before rounding
  localparam int RndW     = 36;  // ProdW after the Q30 rounding shift

  localparam logic signed [XyW-1:0] CordicGain = 34'sd652032874;

  // Degree to binary angle: long division by 360, four quotient bits per cell
  localparam int DivW    = 44;
  localparam int DivStep = 4;
  localparam int DivCells = DivW / DivStep;
  localparam int DivRemW = 9;
  localparam logic [DivRemW:0] DegTurn   = 10'd360;
  localparam logic [DivW-1:0]  DegRound  = 44'd180;
  localparam int               TurnHiDiv = 45;   // 360 = 45 * 8

  localparam logic [1:0] LastCol = 2'd3;

  typedef logic signed [31:0] q16_t;

  typedef enum logic [1:0] {
    QuadI   = 2'd0,
    QuadII  = 2'd1,
    QuadIII = 2'd2,
    QuadIV  = 2'd3
  } quad_e;

  typedef struct packed {
    q16_t [2:0] pos;
    q16_t [2:0] scl;
  } side_t;

  typedef struct packed {
    logic [DivW-1:0]    num;
    logic [DivRemW-1:0] rem;
    logic [TurnW-1:0]   quo;
  } div_lane_t;

  typedef struct packed {
    logic             valid;
    div_lane_t [2:0]  lane;
    side_t            side;
  } div_stage_t;

  typedef struct packed {
    logic signed [XyW-1:0] x;
    logic signed [XyW-1:0] y;
    logic signed [ZW-1:0]  z;
    quad_e                 quad;
  } cordic_lane_t;

  typedef struct packed {
    logic                valid;
    cordic_lane_t [2:0]  lane;
    side_t               side;
  } cordic_stage_t;

  // ent[col][row]
  typedef struct packed {
    q16_t [2:0][2:0] ent;
    q16_t [2:0]      pos;
  } col_load_t;

  function automatic logic [ZW-1:0] atan_turn(input int idx);
    logic [ZW-1:0] v;
    unique case (idx)
      0:  v = 33'd536870912;
      1:  v = 33'd316933406;
      2:  v = 33'd167458907;
      3:  v = 33'd85004756;
      4:  v = 33'd42667331;
      5:  v = 33'd21354465;
      6:  v = 33'd10679838;
      7:  v = 33'd5340245;
      8:  v = 33'd2670163;
      9:  v = 33'd1335087;
      10: v = 33'd667544;
      11: v = 33'd333772;
      12: v = 33'd166886;
      13: v = 33'd83443;
      14: v = 33'd41722;
      15: v = 33'd20861;
      16: v = 33'd10430;
      17: v = 33'd5215;
      18: v = 33'd2608;
      19: v = 33'd1304;
      20: v = 33'd652;
      21: v = 33'd326;
      22: v = 33'd163;
      23: v = 33'd81;
      24: v = 33'd41;
      25: v = 33'd20;
      26: v = 33'd10;
      27: v = 33'd5;
      28: v = 33'd3;
      29: v = 33'd1;
      default: v = '0;
    endcase
    return v;
  endfunction

  // Q30 rounding: add half, arithmetic shift right by 30
  function automatic logic signed [RndW-1:0] rnd30(input logic signed [ProdW-1:0] p);
    logic signed [ProdW-1:0] t;
    t = (p + ProdW'(64'sd536870912)) >>> 30;
    return t[RndW-1:0];
  endfunction

  function automatic q16_t sat32(input logic signed [RndW-1:0] v);
    q16_t r;
    priority if (v > RndW'(64'sd2147483647)) r = 32'sh7fffffff;
    else if (v < -RndW'(64'sd2147483648)) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

FILE: design/trsmc_if.sv
// ----------------------------------------------------------------------------
// trsmc_in_if / trsmc_out_if
// Valid/ready channels of the TRS matrix core: input pose word, output column.
// ----------------------------------------------------------------------------
interface trsmc_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  logic signed [31:0] angle_x_deg;
  logic signed [31:0] angle_y_deg;
  logic signed [31:0] angle_z_deg;
  logic signed [31:0] scale_x;
  logic signed [31:0] scale_y;
  logic signed [31:0] scale_z;

  modport source (output valid, pos_x, pos_y, pos_z, angle_x_deg, angle_y_deg,
                  angle_z_deg, scale_x, scale_y, scale_z, input ready);
  modport sink   (input valid, pos_x, pos_y, pos_z, angle_x_deg, angle_y_deg,
                  angle_z_deg, scale_x, scale_y, scale_z, output ready);
endinterface

interface trsmc_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         column_index;
  logic signed [31:0] entry_row0;
  logic signed [31:0] entry_row1;
  logic signed [31:0] entry_row2;
  logic signed [31:0] entry_row3;
  logic               last_column;

  modport source (output valid, column_index, entry_row0, entry_row1, entry_row2,
                  entry_row3, last_column, input ready);
  modport sink   (input valid, column_index, entry_row0, entry_row1, entry_row2,
                  entry_row3, last_column, output ready);
endinterface

FILE: design/trsmc_div_cell.sv
// ----------------------------------------------------------------------------
// trsmc_div_cell
// One cell of the divide-by-360 chain: four restoring steps on three lanes.
// ----------------------------------------------------------------------------
module trsmc_div_cell
  import trsmc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       en_i,
  input  div_stage_t stage_i,
  output div_stage_t stage_o
);

  div_stage_t         stage_d, stage_q;
  logic               valid_q;
  logic [DivRemW:0]   trial;

  always_comb begin
    stage_d = stage_i;
    trial   = '0;
    for (int l = 0; l < 3; l++) begin
      for (int b = 0; b < DivStep; b++) begin
        trial = {stage_d.lane[l].rem, stage_d.lane[l].num[DivW-1]};
        stage_d.lane[l].num = {stage_d.lane[l].num[DivW-2:0], 1'b0};
        if (trial >= DegTurn) begin
          stage_d.lane[l].rem = DivRemW'(trial - DegTurn);
          stage_d.lane[l].quo = {stage_d.lane[l].quo[TurnW-2:0], 1'b1};
        end else begin
          stage_d.lane[l].rem = trial[DivRemW-1:0];
          stage_d.lane[l].quo = {stage_d.lane[l].quo[TurnW-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= stage_d.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      stage_q <= stage_d;
    end
  end

  always_comb begin
    stage_o       = stage_q;
    stage_o.valid = valid_q;
  end

endmodule

FILE: design/trsmc_cordic_cell.sv
// ----------------------------------------------------------------------------
// trsmc_cordic_cell
// One rotation-mode CORDIC micro-rotation for the three angle lanes.
// ----------------------------------------------------------------------------
module trsmc_cordic_cell
  import trsmc_pkg::*;
#(
  parameter int Idx = 0
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  cordic_stage_t stage_i,
  output cordic_stage_t stage_o
);

  localparam logic signed [ZW-1:0] Atan = $signed(atan_turn(Idx));

  cordic_stage_t         stage_d, stage_q;
  logic                  valid_q;
  logic signed [XyW-1:0] xi [3];
  logic signed [XyW-1:0] yi [3];
  logic signed [ZW-1:0]  zi [3];

  always_comb begin
    stage_d = stage_i;
    for (int l = 0; l < 3; l++) begin
      xi[l] = $signed(stage_i.lane[l].x);
      yi[l] = $signed(stage_i.lane[l].y);
      zi[l] = $signed(stage_i.lane[l].z);
      if (!zi[l][ZW-1]) begin
        stage_d.lane[l].x = xi[l] - (yi[l] >>> Idx);
        stage_d.lane[l].y = yi[l] + (xi[l] >>> Idx);
        stage_d.lane[l].z = zi[l] - Atan;
      end else begin
        stage_d.lane[l].x = xi[l] + (yi[l] >>> Idx);
        stage_d.lane[l].y = yi[l] - (xi[l] >>> Idx);
        stage_d.lane[l].z = zi[l] + Atan;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= stage_d.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      stage_q <= stage_d;
    end
  end

  always_comb begin
    stage_o       = stage_q;
    stage_o.valid = valid_q;
  end

endmodule

FILE: design/trsmc_rot_matrix.sv
// ----------------------------------------------------------------------------
// trsmc_rot_matrix
// Quadrant fold, Rz*Ry*Rx products in Q30 and per-column scaling, six stages.
// ----------------------------------------------------------------------------
module trsmc_rot_matrix
  import trsmc_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  cordic_stage_t stage_i,
  output logic          valid_o,
  output col_load_t     load_o
);

  localparam int Depth = 6;

  // first-level product slots
  localparam int PCzSy = 0;
  localparam int PSzSy = 1;
  localparam int PCzCy = 2;
  localparam int PSzCx = 3;
  localparam int PSzSx = 4;
  localparam int PSzCy = 5;
  localparam int PCzCx = 6;
  localparam int PCzSx = 7;
  localparam int PCySx = 8;
  localparam int PCyCx = 9;
  localparam int NProd = 10;

  logic [Depth-1:0]        v_q;
  side_t                   side_q [Depth];

  q16_t                    cs [3];
  q16_t                    sn [3];
  logic signed [XyW-1:0]   xm [3];
  logic signed [XyW-1:0]   ym [3];

  logic signed [ProdW-1:0] p1_q [NProd];
  q16_t                    sx1_q, cx1_q, sy1_q;
  logic signed [Rq30W-1:0] r2_q [NProd];
  q16_t                    sx2_q, cx2_q, sy2_q;
  logic signed [ProdW-1:0] p3_q [4];
  logic signed [Rq30W-1:0] r3_q [NProd];
  q16_t                    sy3_q;
  logic signed [Rq30W-1:0] rm_q [3][3];
  logic signed [ProdW-1:0] p5_q [3][3];
  q16_t                    e6_q [3][3];

  // fold the quadrant back in: lane 0 = x, 1 = y, 2 = z
  always_comb begin
    for (int l = 0; l < 3; l++) begin
      xm[l] = $signed(stage_i.lane[l].x);
      ym[l] = $signed(stage_i.lane[l].y);
      unique case (stage_i.lane[l].quad)
        QuadI: begin
          cs[l] = xm[l][31:0];
          sn[l] = ym[l][31:0];
        end
        QuadII: begin
          cs[l] = 32'(-ym[l]);
          sn[l] = xm[l][31:0];
        end
        QuadIII: begin
          cs[l] = 32'(-xm[l]);
          sn[l] = 32'(-ym[l]);
        end
        QuadIV: begin
          cs[l] = ym[l][31:0];
          sn[l] = 32'(-xm[l]);
        end
        default: begin
          cs[l] = '0;
          sn[l] = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[Depth-2:0], stage_i.valid};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q[0] <= stage_i.side;
      for (int k = 1; k < Depth; k++) begin
        side_q[k] <= side_q[k-1];
      end

      // stage 1: first-level products
      p1_q[PCzSy] <= cs[2] * sn[1];
      p1_q[PSzSy] <= sn[2] * sn[1];
      p1_q[PCzCy] <= cs[2] * cs[1];
      p1_q[PSzCx] <= sn[2] * cs[0];
      p1_q[PSzSx] <= sn[2] * sn[0];
      p1_q[PSzCy] <= sn[2] * cs[1];
      p1_q[PCzCx] <= cs[2] * cs[0];
      p1_q[PCzSx] <= cs[2] * sn[0];
      p1_q[PCySx] <= cs[1] * sn[0];
      p1_q[PCyCx] <= cs[1] * cs[0];
      sx1_q <= sn[0];
      cx1_q <= cs[0];
      sy1_q <= sn[1];

      // stage 2: back to Q30
      for (int k = 0; k < NProd; k++) begin
        r2_q[k] <= Rq30W'(rnd30(p1_q[k]));
      end
      sx2_q <= sx1_q;
      cx2_q <= cx1_q;
      sy2_q <= sy1_q;

      // stage 3: second-level products
      p3_q[0] <= r2_q[PCzSy] * sx2_q;
      p3_q[1] <= r2_q[PCzSy] * cx2_q;
      p3_q[2] <= r2_q[PSzSy] * sx2_q;
      p3_q[3] <= r2_q[PSzSy] * cx2_q;
      r3_q    <= r2_q;
      sy3_q   <= sy2_q;

      // stage 4: rotation entries
      rm_q[0][0] <= r3_q[PCzCy];
      rm_q[0][1] <= Rq30W'(rnd30(p3_q[0])) - r3_q[PSzCx];
      rm_q[0][2] <= Rq30W'(rnd30(p3_q[1])) + r3_q[PSzSx];
      rm_q[1][0] <= r3_q[PSzCy];
      rm_q[1][1] <= Rq30W'(rnd30(p3_q[2])) + r3_q[PCzCx];
      rm_q[1][2] <= Rq30W'(rnd30(p3_q[3])) - r3_q[PCzSx];
      rm_q[2][0] <= -Rq30W'(sy3_q);
      rm_q[2][1] <= r3_q[PCySx];
      rm_q[2][2] <= r3_q[PCyCx];

      // stage 5: scale column j by scale_j
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          p5_q[i][j] <= rm_q[i][j] * $signed(side_q[3].scl[j]);
        end
      end

      // stage 6: round Q46 to Q16 and clamp
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          e6_q[i][j] <= sat32(rnd30(p5_q[i][j]));
        end
      end
    end
  end

  always_comb begin
    load_o.pos = side_q[Depth-1].pos;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        load_o.ent[j][i] = e6_q[i][j];
      end
    end
  end

  assign valid_o = v_q[Depth-1];

endmodule

FILE: design/trsmc_col_out.sv
// ----------------------------------------------------------------------------
// trsmc_col_out
// Output register: holds one finished matrix and sends it a column per word.
// ----------------------------------------------------------------------------
module trsmc_col_out
  import trsmc_pkg::*;
#(
  parameter int FracBits = DefFracBits
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        load_valid_i,
  input  col_load_t   load_i,
  output logic        load_ok_o,
  trsmc_out_if.source col_o
);

  localparam q16_t One = q16_t'(64'sd1 << FracBits);

  logic       valid_q;
  logic [1:0] col_q;
  col_load_t  data_q;
  logic       last_col;

  assign last_col  = (col_q == LastCol);
  assign load_ok_o = !valid_q || (col_o.ready && last_col);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      col_q   <= '0;
    end else if (load_valid_i && load_ok_o) begin
      valid_q <= 1'b1;
      col_q   <= '0;
    end else if (valid_q && col_o.ready) begin
      if (last_col) begin
        valid_q <= 1'b0;
      end
      col_q <= col_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_valid_i && load_ok_o) begin
      data_q <= load_i;
    end
  end

  always_comb begin
    col_o.valid        = valid_q;
    col_o.column_index = col_q;
    col_o.last_column  = last_col;
    if (last_col) begin
      col_o.entry_row0 = data_q.pos[0];
      col_o.entry_row1 = data_q.pos[1];
      col_o.entry_row2 = data_q.pos[2];
      col_o.entry_row3 = One;
    end else begin
      col_o.entry_row0 = data_q.ent[col_q][0];
      col_o.entry_row1 = data_q.ent[col_q][1];
      col_o.entry_row2 = data_q.ent[col_q][2];
      col_o.entry_row3 = '0;
    end
  end

endmodule

FILE: design/trs_matrix_compose_core.sv
// ----------------------------------------------------------------------------
// trs_matrix_compose_core
// Builds the column-major 4x4 transform T*R*S from a pose word.
// ----------------------------------------------------------------------------
// Takes translation, Euler angles in degrees (R = Rz*Ry*Rx) and per-axis scale,
// all signed Q16.16, and returns four column words, column 0 first, the last
// one carrying (tx, ty, tz, 1.0) and last_column set. Scaled entries saturate.
// A pose word passes a two-stage angle reduction, 11 divide-by-360 cells,
// CORDIC_STAGES CORDIC cells, six product stages and the column output
// register. The whole chain moves in lockstep and takes a new word every
// cycle it is not stalled; the single output channel, one column per word
// and four words per pose, limits the sustained pose rate.
// ----------------------------------------------------------------------------
module trs_matrix_compose_core
  import trsmc_pkg::*;
#(
  parameter int CORDIC_STAGES = DefCordicStages,
  parameter int FRAC_BITS     = DefFracBits
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  trsmc_in_if.sink    item_i,
  trsmc_out_if.source col_o
);

  // angle = h * 2^LowW + low, with 360 degrees = 45 * 2^LowW
  localparam int HW    = 29 - FRAC_BITS;
  localparam int LowW  = FRAC_BITS + 3;
  localparam int Kk    = HW + 6;
  localparam int MW    = Kk - 3;
  localparam int PW    = HW + MW;
  localparam int QW    = PW - Kk;
  localparam int RW    = HW + 2;
  localparam int ZeroW = 32 - FRAC_BITS;
  localparam longint MulKInt = ((longint'(1) << Kk) + longint'(TurnHiDiv - 1))
                               / longint'(TurnHiDiv);
  localparam logic signed [MW-1:0] MulK = MW'(MulKInt);
  localparam logic signed [RW-1:0] HiDiv = RW'(TurnHiDiv);

  logic en;
  logic mat_valid;
  logic load_ok;

  q16_t  ang [3];
  side_t side_in;

  assign ang[0] = item_i.angle_x_deg;
  assign ang[1] = item_i.angle_y_deg;
  assign ang[2] = item_i.angle_z_deg;

  assign side_in.pos[0] = item_i.pos_x;
  assign side_in.pos[1] = item_i.pos_y;
  assign side_in.pos[2] = item_i.pos_z;
  assign side_in.scl[0] = item_i.scale_x;
  assign side_in.scl[1] = item_i.scale_y;
  assign side_in.scl[2] = item_i.scale_z;

  // whole chain stalls only when a finished matrix cannot be handed over
  assign en           = !(mat_valid && !load_ok);
  assign item_i.ready = en;

  // --- reduction stage 1: quotient estimate of h / 45 -----------------------
  logic                  r1_valid_q;
  side_t                 r1_side_q;
  logic signed [HW-1:0]  r1_h_q    [3];
  logic [LowW-1:0]       r1_low_q  [3];
  logic signed [PW-1:0]  r1_prod_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r1_valid_q <= 1'b0;
    end else if (en) begin
      r1_valid_q <= item_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      r1_side_q <= side_in;
      for (int l = 0; l < 3; l++) begin
        r1_h_q[l]    <= $signed(ang[l][31:LowW]);
        r1_low_q[l]  <= ang[l][LowW-1:0];
        r1_prod_q[l] <= $signed(ang[l][31:LowW]) * MulK;
      end
    end
  end

  // --- reduction stage 2: floor mod 45, scale up, add rounding half ---------
  logic signed [QW-1:0] quo_est [3];
  logic signed [RW-1:0] rem_raw [3];
  logic signed [RW-1:0] rem_fix [3];
  div_stage_t           r2_d, r2_q;
  logic                 r2_valid_q;

  always_comb begin
    r2_d       = '0;
    r2_d.valid = r1_valid_q;
    r2_d.side  = r1_side_q;
    for (int l = 0; l < 3; l++) begin
      quo_est[l] = r1_prod_q[l][PW-1:Kk];
      rem_raw[l] = RW'(r1_h_q[l]) - RW'(quo_est[l]) * HiDiv;
      // estimate may be one off either way
      priority if (rem_raw[l] < 0) rem_fix[l] = rem_raw[l] + HiDiv;
      else if (rem_raw[l] >= HiDiv) rem_fix[l] = rem_raw[l] - HiDiv;
      else rem_fix[l] = rem_raw[l];
      r2_d.lane[l].num = {3'b000, rem_fix[l][5:0], r1_low_q[l], {ZeroW{1'b0}}}
                         + DegRound;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r2_valid_q <= 1'b0;
    end else if (en) begin
      r2_valid_q <= r2_d.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      r2_q <= r2_d;
    end
  end

  // --- divide-by-360 chain --------------------------------------------------
  div_stage_t div_s [DivCells+1];

  always_comb begin
    div_s[0]       = r2_q;
    div_s[0].valid = r2_valid_q;
  end

  for (genvar k = 0; k < DivCells; k++) begin : g_div
    trsmc_div_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .stage_i (div_s[k]),
      .stage_o (div_s[k+1])
    );
  end

  // --- CORDIC chain ---------------------------------------------------------
  cordic_stage_t cor_s [CORDIC_STAGES+1];

  always_comb begin
    cor_s[0].valid = div_s[DivCells].valid;
    cor_s[0].side  = div_s[DivCells].side;
    for (int l = 0; l < 3; l++) begin
      cor_s[0].lane[l].x    = CordicGain;
      cor_s[0].lane[l].y    = '0;
      cor_s[0].lane[l].z    = {{(ZW-30){1'b0}}, div_s[DivCells].lane[l].quo[29:0]};
      cor_s[0].lane[l].quad = quad_e'(div_s[DivCells].lane[l].quo[TurnW-1:TurnW-2]);
    end
  end

  for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cordic
    trsmc_cordic_cell #(
      .Idx (k)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .stage_i (cor_s[k]),
      .stage_o (cor_s[k+1])
    );
  end

  // --- matrix products and output -------------------------------------------
  col_load_t mat_load;

  trsmc_rot_matrix u_matrix (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .stage_i (cor_s[CORDIC_STAGES]),
    .valid_o (mat_valid),
    .load_o  (mat_load)
  );

  trsmc_col_out #(
    .FracBits (FRAC_BITS)
  ) u_col_out (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_valid_i (mat_valid),
    .load_i       (mat_load),
    .load_ok_o    (load_ok),
    .col_o        (col_o)
  );

endmodule

FILE: verif/trsmc_checker.sv
// ----------------------------------------------------------------------------
// trsmc_checker
// Watches the pose and column channels, predicts each column word and
// compares it field by field with what the core delivers.
// ----------------------------------------------------------------------------
module trsmc_checker
  import trsmc_pkg::*;
#(
  parameter int CORDIC_STAGES = DefCordicStages,
  parameter int FRAC_BITS     = DefFracBits
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  trsmc_in_if.sink    item_i,
  trsmc_out_if.sink   col_o,
  output int          fail_cnt_o,
  output int          pending_o,
  output logic        accept_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [1:0]         idx;
    logic signed [31:0] r0, r1, r2, r3;
    logic               last;
  } column_t;

  column_t col_q[$];
  int      fails;

  localparam longint AtanTab[30] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
    41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
    10, 5, 3, 1};

  function automatic longint round_q30(longint v);
    return (v + (64'sd1 <<< 29)) >>> 30;
  endfunction

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  task automatic sincos(input logic signed [31:0] ang, output longint c,
                        output longint s);
    longint full, r, x, y, z, nx;
    logic [63:0] turn;
    logic [1:0] q;
    full = 64'sd360 <<< FRAC_BITS;
    r = longint'(ang) % full;
    if (r < 0) r += full;
    turn = ((64'(r) << (32 - FRAC_BITS)) + 64'd180) / 64'd360;
    turn &= 64'hFFFF_FFFF;
    q = turn[31:30];
    z = longint'(turn[29:0]);
    x = 652032874; y = 0;
    for (int i = 0; i < CORDIC_STAGES && i < 30; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i); y = y + (x >>> i); z -= AtanTab[i];
      end else begin
        nx = x + (y >>> i); y = y - (x >>> i); z += AtanTab[i];
      end
      x = nx;
    end
    case (quad_e'(q))
      QuadI:   begin c = x;  s = y;  end
      QuadII:  begin c = -y; s = x;  end
      QuadIII: begin c = -x; s = -y; end
      default: begin c = y;  s = -x; end
    endcase
  endtask

  task automatic predict_columns();
    longint cx, sx, cy, sy, cz, sz, czsy, szsy;
    longint rm[3][3];
    longint sc[3];
    column_t w;
    sincos(item_i.angle_x_deg, cx, sx);
    sincos(item_i.angle_y_deg, cy, sy);
    sincos(item_i.angle_z_deg, cz, sz);
    sc[0] = item_i.scale_x; sc[1] = item_i.scale_y; sc[2] = item_i.scale_z;
    czsy = round_q30(cz * sy);
    szsy = round_q30(sz * sy);
    rm[0][0] = round_q30(cz * cy);
    rm[0][1] = round_q30(czsy * sx) - round_q30(sz * cx);
    rm[0][2] = round_q30(czsy * cx) + round_q30(sz * sx);
    rm[1][0] = round_q30(sz * cy);
    rm[1][1] = round_q30(szsy * sx) + round_q30(cz * cx);
    rm[1][2] = round_q30(szsy * cx) - round_q30(cz * sx);
    rm[2][0] = -sy;
    rm[2][1] = round_q30(cy * sx);
    rm[2][2] = round_q30(cy * cx);
    for (int j = 0; j < 3; j++) begin
      w.idx  = 2'(j);
      w.r0   = 32'(clamp32(round_q30(rm[0][j] * sc[j])));
      w.r1   = 32'(clamp32(round_q30(rm[1][j] * sc[j])));
      w.r2   = 32'(clamp32(round_q30(rm[2][j] * sc[j])));
      w.r3   = '0;
      w.last = 1'b0;
      col_q.push_back(w);
    end
    w.idx = LastCol; w.r0 = item_i.pos_x; w.r1 = item_i.pos_y; w.r2 = item_i.pos_z;
    w.r3 = 32'sd1 <<< FRAC_BITS; w.last = 1'b1;
    col_q.push_back(w);
  endtask

  task automatic check_column();
    column_t e;
    if (col_q.size() == 0) begin
      $display("%0t: unexpected column word idx=%0d", $realtime, col_o.column_index);
      fails++;
      return;
    end
    e = col_q.pop_front();
    if (col_o.column_index !== e.idx || col_o.entry_row0 !== e.r0 ||
        col_o.entry_row1 !== e.r1 || col_o.entry_row2 !== e.r2 ||
        col_o.entry_row3 !== e.r3 || col_o.last_column !== e.last) begin
      $display("%0t: mismatch exp idx=%0d %h %h %h %h last=%0b", $realtime,
               e.idx, e.r0, e.r1, e.r2, e.r3, e.last);
      $display("%0t:          got idx=%0d %h %h %h %h last=%0b", $realtime,
               col_o.column_index, col_o.entry_row0, col_o.entry_row1,
               col_o.entry_row2, col_o.entry_row3, col_o.last_column);
      fails++;
    end
  endtask

  initial fails = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (item_i.valid && item_i.ready) predict_columns();
      if (col_o.valid && col_o.ready) check_column();
    end
  end

  assign fail_cnt_o = fails;
  assign pending_o  = col_q.size();
  assign accept_o   = (item_i.valid && item_i.ready) || (col_o.valid && col_o.ready);
endmodule

FILE: verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives pose words into the TRS matrix core with bursty traffic and a
// stalling receiver; the checker predicts and compares every column word.
// ----------------------------------------------------------------------------
module tb_top
  import trsmc_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NumRandom  = 260;
  localparam int Latency    = 19 + DefCordicStages + 8;
  localparam int IdleLimit  = 20000;
  localparam int HoldCycles = 300;

  logic clk_i, rst_ni;
  int   fail_cnt, pending;
  logic accept;
  logic long_hold;
  logic hold_done;
  int   idle_cycles;

  trsmc_in_if  item_if ();
  trsmc_out_if col_if ();

  trs_matrix_compose_core u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .item_i (item_if.sink),
    .col_o  (col_if.source)
  );

  trsmc_checker u_chk (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .item_i     (item_if.sink),
    .col_o      (col_if.sink),
    .fail_cnt_o (fail_cnt),
    .pending_o  (pending),
    .accept_o   (accept)
  );

  always begin
    clk_i = 1'b1; #4;
    clk_i = 1'b0; #4;
  end

  function automatic logic signed [31:0] rand_field(input int mode);
    case (mode)
      0: return $urandom();
      1: return 32'sh7fffffff;
      2: return 32'sh80000000;
      default: return $signed($urandom_range(0, 8 << 16)) - (4 << 16);
    endcase
  endfunction

  task automatic send_pose(input logic signed [31:0] f[9]);
    item_if.valid <= 1'b1;
    item_if.pos_x <= f[0]; item_if.pos_y <= f[1]; item_if.pos_z <= f[2];
    item_if.angle_x_deg <= f[3]; item_if.angle_y_deg <= f[4];
    item_if.angle_z_deg <= f[5];
    item_if.scale_x <= f[6]; item_if.scale_y <= f[7]; item_if.scale_z <= f[8];
    do @(posedge clk_i); while (!item_if.ready);
    @(negedge clk_i);
  endtask

  task automatic drop_valid(input int gap);
    item_if.valid <= 1'b0;
    repeat (gap) @(negedge clk_i);
  endtask

  // receiver: own stall pattern, plus one long hold-off timed here
  initial begin
    col_if.ready = 1'b0;
    hold_done = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (long_hold && !hold_done) begin
        col_if.ready <= 1'b0;
        repeat (HoldCycles) @(negedge clk_i);
        hold_done = 1'b1;
      end
      col_if.ready <= ($urandom_range(0, 3) != 0);
    end
  end

  always @(posedge clk_i) begin
    if (accept || !rst_ni) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IdleLimit) begin
      $display("FAIL trs_matrix_compose_core");
      $finish;
    end
  end

  initial begin
    logic signed [31:0] f[9];
    int burst;
    rst_ni = 1'b0;
    long_hold = 1'b0;
    idle_cycles = 0;
    item_if.valid = 1'b0;
    item_if.pos_x = '0; item_if.pos_y = '0; item_if.pos_z = '0;
    item_if.angle_x_deg = '0; item_if.angle_y_deg = '0; item_if.angle_z_deg = '0;
    item_if.scale_x = '0; item_if.scale_y = '0; item_if.scale_z = '0;
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: quadrant corners, negative and huge angles, saturating scales
    for (int d = 0; d < 22; d++) begin
      for (int k = 0; k < 9; k++) f[k] = rand_field(d % 4);
      case (d)
        0: foreach (f[k]) f[k] = 0;
        1: begin f[3] = 90 << 16; f[4] = 180 << 16; f[5] = 270 << 16; end
        2: begin f[3] = -(90 << 16); f[4] = -(360 << 16); f[5] = 360 << 16; end
        3: foreach (f[k]) f[k] = 32'sh7fffffff;
        4: foreach (f[k]) f[k] = 32'sh80000000;
        5: begin f[3] = 45 << 16; f[4] = 30 << 16; f[5] = 60 << 16;
                 f[6] = 1 << 16; f[7] = 1 << 16; f[8] = 1 << 16; end
        6: begin f[3] = 0; f[4] = 0; f[5] = 0; f[6] = 32'sh80000000;
                 f[7] = 32'sh7fffffff; f[8] = 32'sh80000000; end
        7: begin f[3] = 32'sh80000000; f[4] = 180 << 16; f[5] = -(180 << 16); end
        8: begin f[3] = 1; f[4] = -1; f[5] = (360 << 16) - 1; end
        default: ;
      endcase
      send_pose(f);
    end
    drop_valid(0);

    // pause until every expected column has come
    while (pending != 0) @(negedge clk_i);

    for (int n = 0; n < NumRandom; ) begin
      burst = $urandom_range(1, 12);
      if (n >= 100) long_hold = 1'b1;
      for (int b = 0; b < burst && n < NumRandom; b++, n++) begin
        for (int k = 0; k < 9; k++) f[k] = rand_field($urandom_range(0, 9) < 6 ? 0 :
                                                        $urandom_range(1, 3));
        send_pose(f);
      end
      if ($urandom_range(0, 2) != 0) drop_valid($urandom_range(1, 20));
    end
    drop_valid(0);

    while (pending != 0) @(negedge clk_i);
    repeat (Latency) @(negedge clk_i);
    if (fail_cnt == 0 && pending == 0) begin
      $display("PASS trs_matrix_compose_core");
    end else begin
      $display("FAIL trs_matrix_compose_core");
    end
    $finish;
  end
endmodule

FILE: trs_matrix_compose_core.f
design/trsmc_pkg.sv
design/trsmc_if.sv
design/trsmc_div_cell.sv
design/trsmc_cordic_cell.sv
design/trsmc_rot_matrix.sv
design/trsmc_col_out.sv
design/trs_matrix_compose_core.sv
verif/trsmc_checker.sv
verif/tb_top.sv
